### sv/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

  localparam int unsigned TABLE_GROUPS = 21;

  localparam int unsigned FreqW  = 16;
  localparam int unsigned DeltaW = 15;
  localparam int unsigned RecipW = 17;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned SlotW  = 12;
  localparam int unsigned GroupW = 5;
  localparam int unsigned AddrW  = 18;
  localparam int unsigned ProdW  = 23;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  localparam logic [16:0] BaseAddrReset = 17'd80000;
  localparam logic [15:0] AntOffsetReset = 16'd4000;

  typedef enum logic [1:0] {
    RegAntennaSelect = 2'd0,
    RegBaseAddress   = 2'd1,
    RegAntennaOffset = 2'd2
  } reg_addr_e;

  typedef struct packed {
    logic        antenna_select;
    logic [16:0] base_address;
    logic [15:0] antenna_offset;
  } cfg_t;

  // group table, bounds inclusive
  localparam logic [FreqW-1:0] GroupLo [TABLE_GROUPS] = '{
    16'd1,     16'd1800,  16'd2001,  16'd3500,  16'd4001,  16'd7000,  16'd7301,
    16'd10010, 16'd10151, 16'd14000, 16'd14351, 16'd18068, 16'd18169, 16'd21000,
    16'd21451, 16'd24890, 16'd24991, 16'd28000, 16'd29701, 16'd50000, 16'd54001
  };

  localparam logic [FreqW-1:0] GroupHi [TABLE_GROUPS] = '{
    16'd1799,  16'd2000,  16'd3499,  16'd4000,  16'd6999,  16'd7300,  16'd10009,
    16'd10150, 16'd13999, 16'd14350, 16'd18067, 16'd18168, 16'd20999, 16'd21450,
    16'd24889, 16'd24990, 16'd27999, 16'd29700, 16'd49999, 16'd54000, 16'd55000
  };

  localparam logic [CountW-1:0] GroupCnt [TABLE_GROUPS] = '{
    8'd200, 8'd100, 8'd200, 8'd200, 8'd200, 8'd100, 8'd200,
    8'd100, 8'd200, 8'd100, 8'd200, 8'd100, 8'd200, 8'd200,
    8'd200, 8'd100, 8'd200, 8'd200, 8'd200, 8'd200, 8'd100
  };

  // running sum of the counts of all earlier groups
  localparam logic [SlotW-1:0] GroupBase [TABLE_GROUPS] = '{
    12'd0,    12'd200,  12'd300,  12'd500,  12'd700,  12'd900,  12'd1000,
    12'd1200, 12'd1300, 12'd1500, 12'd1600, 12'd1800, 12'd1900, 12'd2100,
    12'd2300, 12'd2500, 12'd2600, 12'd2800, 12'd3000, 12'd3200, 12'd3400
  };

endpackage

`default_nettype wire

### sv/ffsa_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ffsa_regs
  import ffsa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t      cfg_q, cfg_d;
  reg_addr_e sel;
  logic      wr_en;

  assign pready = 1'b1;
  assign sel    = reg_addr_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        RegAntennaSelect: cfg_d.antenna_select = pwdata[0];
        RegBaseAddress:   cfg_d.base_address   = pwdata[16:0];
        RegAntennaOffset: cfg_d.antenna_offset = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.antenna_select <= 1'b0;
      cfg_q.base_address   <= BaseAddrReset;
      cfg_q.antenna_offset <= AntOffsetReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (sel)
      RegAntennaSelect: prdata = {31'd0, cfg_q.antenna_select};
      RegBaseAddress:   prdata = {15'd0, cfg_q.base_address};
      RegAntennaOffset: prdata = {16'd0, cfg_q.antenna_offset};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/frequency_to_flash_slot_address.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                   payload
// in       request    in_valid_i / in_stall_o     frequency_khz_i
// out      result     out_valid_o / out_stall_i   flash_address_o, slot_index_o,
//                                                 group_index_o, invalid_o
// config   apb        psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// five register stages: group search, delta and reciprocal multiply, two
// check products, remainder correction and base sum, address add.
// one request per cycle while out_stall_i holds no stage; a request passes through
// the stage registers in order, and out_valid_o rises when it reaches the last.
// each stage holds when the one after it is full and held, so bubbles close up
// and a request is taken while a finished result waits.
// reset clears stage valid bits and loads the register reset values.

module frequency_to_flash_slot_address
  import ffsa_pkg::*;
#(
  parameter int unsigned GROUP_COUNT = 21
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [FreqW-1:0]  frequency_khz_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [AddrW-1:0]  flash_address_o,
  output logic      [SlotW-1:0]  slot_index_o,
  output logic      [GroupW-1:0] group_index_o,
  output logic                   invalid_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned SearchGroups =
    (GROUP_COUNT < TABLE_GROUPS) ? GROUP_COUNT : TABLE_GROUPS;

  cfg_t cfg;

  ffsa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // per-group reciprocal floor(2^16 * count / span) and span
  logic [RecipW-1:0] recip_tab [TABLE_GROUPS];
  logic [DeltaW-1:0] span_tab  [TABLE_GROUPS];

  for (genvar g = 0; g < TABLE_GROUPS; g++) begin : g_tab
    localparam int unsigned Span  = int'(GroupHi[g]) - int'(GroupLo[g]);
    localparam int unsigned Recip = (Span == 0) ? 0 :
                                    ((1 << RecipShift) * int'(GroupCnt[g])) / Span;
    assign recip_tab[g] = RecipW'(Recip);
    assign span_tab[g]  = DeltaW'(Span);
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5_q || !out_stall_i;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  // stage 1: group search
  logic [SearchGroups-1:0] hit;
  logic [GroupW-1:0]       grp1_d;
  logic [FreqW-1:0]        f1_q;
  logic [GroupW-1:0]       grp1_q;
  logic                    found1_q;

  for (genvar g = 0; g < SearchGroups; g++) begin : g_hit
    assign hit[g] = (frequency_khz_i >= GroupLo[g]) && (frequency_khz_i <= GroupHi[g]);
  end

  // groups do not overlap, so at most one bit is set
  always_comb begin
    grp1_d = '0;
    for (int g = 0; g < SearchGroups; g++) begin
      if (hit[g]) grp1_d = grp1_d | GroupW'(g);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      f1_q     <= frequency_khz_i;
      grp1_q   <= grp1_d;
      found1_q <= |hit;
    end
  end

  // stage 2: delta into the group and reciprocal estimate
  logic [DeltaW-1:0]   d1;
  logic [31:0]         prod1;
  logic [DeltaW-1:0]   d2_q;
  logic [CountW-1:0]   qe2_q;
  logic [GroupW-1:0]   grp2_q;
  logic                found2_q;

  assign d1    = DeltaW'(f1_q - GroupLo[grp1_q]);
  assign prod1 = {17'd0, d1} * {15'd0, recip_tab[grp1_q]};

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      d2_q     <= d1;
      qe2_q    <= prod1[RecipShift +: CountW];
      grp2_q   <= grp1_q;
      found2_q <= found1_q;
    end
  end

  // stage 3: exact products for the remainder check
  logic [ProdW-1:0]  qs3_q, dc3_q;
  logic [CountW-1:0] qe3_q;
  logic [GroupW-1:0] grp3_q;
  logic              found3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      qs3_q    <= ProdW'({15'd0, qe2_q} * {8'd0, span_tab[grp2_q]});
      dc3_q    <= ProdW'({8'd0, d2_q} * {15'd0, GroupCnt[grp2_q]});
      qe3_q    <= qe2_q;
      grp3_q   <= grp2_q;
      found3_q <= found2_q;
    end
  end

  // stage 4: estimate is at most one low, fix it and add the group base
  logic [ProdW-1:0]  rem3;
  logic              corr3;
  logic [SlotW-1:0]  slot4_q;
  logic [GroupW-1:0] grp4_q;
  logic              found4_q;

  assign rem3  = dc3_q - qs3_q;
  assign corr3 = rem3 >= ProdW'(span_tab[grp3_q]);

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      slot4_q  <= found3_q ?
                  GroupBase[grp3_q] + SlotW'(qe3_q) + SlotW'(corr3) : '0;
      grp4_q   <= found3_q ? grp3_q : '0;
      found4_q <= found3_q;
    end
  end

  // stage 5: byte address
  logic [AddrW-1:0]  addr4;
  logic [AddrW-1:0]  addr5_q;
  logic [SlotW-1:0]  slot5_q;
  logic [GroupW-1:0] grp5_q;
  logic              inv5_q;

  assign addr4 = AddrW'({slot4_q, 1'b0}) + AddrW'(cfg.base_address) +
                 (cfg.antenna_select ? AddrW'(cfg.antenna_offset) : '0);

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      addr5_q <= found4_q ? addr4 : '0;
      slot5_q <= slot4_q;
      grp5_q  <= grp4_q;
      inv5_q  <= !found4_q;
    end
  end

  assign out_valid_o     = v5_q;
  assign flash_address_o = addr5_q;
  assign slot_index_o    = slot5_q;
  assign group_index_o   = grp5_q;
  assign invalid_o       = inv5_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input held while a stage is empty");

  a_hold_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out_stall_i && v4_q) |=> v4_q)
    else $error("request dropped behind a held result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |->
      (flash_address_o == '0 && slot_index_o == '0 && group_index_o == '0))
    else $error("invalid result carries nonzero fields");

  // base and offset may be odd, so only the slot range is checked
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (slot_index_o <= SlotW'(3500)))
    else $error("slot out of range");

endmodule

`default_nettype wire

### tb/tb_frequency_to_flash_slot_address.sv
`timescale 1ns / 1ps

module tb_frequency_to_flash_slot_address
  import ffsa_pkg::*;
();

  localparam int unsigned NUM_GROUPS = 21;
  localparam int unsigned BANDS = 21;
  localparam int unsigned KHZ_LOW = 1;
  localparam int unsigned KHZ_HIGH = 55000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [PaddrW-1:0] ADDR_SEL  = PaddrW'(RegAntennaSelect) << 2;
  localparam logic [PaddrW-1:0] ADDR_BASE = PaddrW'(RegBaseAddress) << 2;
  localparam logic [PaddrW-1:0] ADDR_OFF  = PaddrW'(RegAntennaOffset) << 2;
  // one past the last register, writes there must be dropped
  localparam logic [PaddrW-1:0] ADDR_UNUSED = PaddrW'(int'(RegAntennaOffset) + 1) << 2;

  localparam int unsigned BAND_LO [BANDS] = '{
    1, 1800, 2001, 3500, 4001, 7000, 7301, 10010, 10151, 14000, 14351,
    18068, 18169, 21000, 21451, 24890, 24991, 28000, 29701, 50000, 54001
  };
  localparam int unsigned BAND_HI [BANDS] = '{
    1799, 2000, 3499, 4000, 6999, 7300, 10009, 10150, 13999, 14350, 18067,
    18168, 20999, 21450, 24889, 24990, 27999, 29700, 49999, 54000, 55000
  };
  localparam int unsigned BAND_SLOTS [BANDS] = '{
    200, 100, 200, 200, 200, 100, 200, 100, 200, 100, 200,
    100, 200, 200, 200, 100, 200, 200, 200, 200, 100
  };

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [SlotW-1:0]  slot;
    logic [GroupW-1:0] grp;
    logic              inv;
  } lookup_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic [FreqW-1:0]  in_freq = '0;
  logic              rcv_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;

  wire logic              in_stall;
  wire logic              out_valid;
  wire logic              out_stall;
  wire logic [AddrW-1:0]  flash_address;
  wire logic [SlotW-1:0]  slot_index;
  wire logic [GroupW-1:0] group_index;
  wire logic              invalid;
  wire logic [PdataW-1:0] prdata;
  wire logic              pready;

  // shadow copy of the registers
  logic        cfg_sel = 1'b0;
  logic [16:0] cfg_base = BaseAddrReset;
  logic [15:0] cfg_off = AntOffsetReset;

  logic [FreqW-1:0] freq_q [$];
  lookup_t          lookup_q [$];

  int unsigned send_gap_max = 6;
  int unsigned rcv_gap_max = 6;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned mismatches = 0;

  assign out_stall = rcv_stall || (hold_left != 0);

  frequency_to_flash_slot_address #(
    .GROUP_COUNT(NUM_GROUPS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .frequency_khz_i(in_freq),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .flash_address_o(flash_address),
    .slot_index_o   (slot_index),
    .group_index_o  (group_index),
    .invalid_o      (invalid),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("frequency_to_flash_slot_address verification failed");
    $finish;
  end

  function automatic lookup_t calc_lookup(input logic [FreqW-1:0] freq);
    lookup_t     r;
    int unsigned f;
    int unsigned acc;
    int unsigned part;
    int unsigned sum;
    logic        hit;
    r = '0;
    f = freq;
    acc = 0;
    hit = 1'b0;
    if (f >= KHZ_LOW && f <= KHZ_HIGH) begin
      for (int unsigned g = 0; g < NUM_GROUPS && g < BANDS; g++) begin
        if (!hit && f >= BAND_LO[g] && f <= BAND_HI[g]) begin
          part = (f - BAND_LO[g]) * BAND_SLOTS[g] / (BAND_HI[g] - BAND_LO[g]);
          r.slot = SlotW'(acc + part);
          r.grp = GroupW'(g);
          hit = 1'b1;
        end
        acc += BAND_SLOTS[g];
      end
    end
    if (hit) begin
      sum = (int'(r.slot) << 1) + cfg_base + (cfg_sel ? cfg_off : 0);
      r.addr = AddrW'(sum);
    end else begin
      r.inv = 1'b1;
    end
    return r;
  endfunction

  // mostly in-range values, heavy on group edges
  function automatic logic [FreqW-1:0] rand_freq();
    int unsigned kind;
    int unsigned g;
    kind = $urandom_range(0, 9);
    g = $urandom_range(0, BANDS - 1);
    case (kind)
      0: return FreqW'($urandom());
      1: return ($urandom_range(0, 3) == 0) ? '0 :
                FreqW'($urandom_range(KHZ_HIGH + 1, 65535));
      2, 3: begin
        case ($urandom_range(0, 3))
          0: return FreqW'(BAND_LO[g]);
          1: return FreqW'(BAND_HI[g]);
          2: return FreqW'(BAND_LO[g] + 1);
          default: return FreqW'(BAND_HI[g] - 1);
        endcase
      end
      default: return FreqW'($urandom_range(BAND_LO[g], BAND_HI[g]));
    endcase
  endfunction

  task automatic reg_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_SEL:  cfg_sel = data[0];
      ADDR_BASE: cfg_base = data[16:0];
      ADDR_OFF:  cfg_off = data[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (freq_q.size() != 0 || in_valid || lookup_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) freq_q.push_back(rand_freq());
  endtask

  // request driver
  always @(posedge clk_i) begin
    logic fire;
    logic load;
    fire = in_valid && !in_stall;
    load = 1'b0;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (fire) begin
        lookup_q.push_back(calc_lookup(in_freq));
      end
      if (!in_valid || fire) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (freq_q.size() != 0) begin
          load = 1'b1;
          in_freq <= freq_q.pop_front();
          gap_left <= $urandom_range(0, send_gap_max);
        end
        in_valid <= load;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    lookup_t     want;
    lookup_t     got;
    int unsigned wait_n;
    got = {flash_address, slot_index, group_index, invalid};
    wait_n = stall_left;
    if (!rst_ni) begin
      rcv_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: addr=%0d slot=%0d group=%0d invalid=%0b",
                     got.addr, got.slot, got.grp, got.inv);
        end else begin
          want = lookup_q.pop_front();
          if (got.addr !== want.addr || got.slot !== want.slot ||
              got.grp !== want.grp || got.inv !== want.inv) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: exp addr=%0d slot=%0d group=%0d invalid=%0b,",
                        " got addr=%0d slot=%0d group=%0d invalid=%0b"},
                       want.addr, want.slot, want.grp, want.inv,
                       got.addr, got.slot, got.grp, got.inv);
          end
        end
        wait_n = $urandom_range(0, rcv_gap_max);
      end
      if (wait_n != 0) begin
        rcv_stall <= 1'b1;
        stall_left <= wait_n - 1;
      end else begin
        rcv_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // long receiver hold-off, one per request from the sequence
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    logic [FreqW-1:0] edge_freqs [$];
    edge_freqs = '{16'd0, 16'd1, 16'd2, 16'd1799, 16'd1800, 16'd2000, 16'd2001,
                   16'd3499, 16'd3500, 16'd4000, 16'd7000, 16'd10009, 16'd10010,
                   16'd14350, 16'd21450, 16'd29700, 16'd49999, 16'd50000,
                   16'd54000, 16'd54001, 16'd55000, 16'd55001, 16'd65535,
                   16'd32768, 16'hAAAA};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values of the registers, directed edges
    foreach (edge_freqs[i]) freq_q.push_back(edge_freqs[i]);
    wait_idle();

    for (int unsigned ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: begin
          // all ones, masked down to the widest values
          reg_write(ADDR_SEL, '1);
          reg_write(ADDR_BASE, '1);
          reg_write(ADDR_OFF, '1);
          send_gap_max = 6;
          rcv_gap_max = 6;
        end
        2: begin
          reg_write(ADDR_SEL, '0);
          reg_write(ADDR_BASE, '0);
          reg_write(ADDR_OFF, '0);
          send_gap_max = 0;
          rcv_gap_max = 0;
        end
        3: begin
          reg_write(ADDR_SEL, 32'h1);
          reg_write(ADDR_OFF, 32'hFFFF);
          reg_write(ADDR_UNUSED, $urandom());
          send_gap_max = 0;
          rcv_gap_max = 6;
        end
        4, 5: begin
          reg_write(ADDR_SEL, $urandom());
          reg_write(ADDR_BASE, $urandom());
          reg_write(ADDR_OFF, $urandom());
          send_gap_max = (ph == 4) ? 6 : 2;
          rcv_gap_max = (ph == 4) ? 2 : 6;
        end
        default: begin
          reg_write(ADDR_SEL, '0);
          reg_write(ADDR_BASE, 32'h1FFFF);
          reg_write(ADDR_OFF, $urandom());
          send_gap_max = 6;
          rcv_gap_max = 6;
        end
      endcase
      @(negedge clk_i);
      if (ph == 3) begin
        // sender pauses midway until the block has drained
        add_random(PHASE_ITEMS / 2);
        wait_idle();
        add_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        add_random(PHASE_ITEMS);
      end
      if (ph == 1 || ph == 5) begin
        while (freq_q.size() > PHASE_ITEMS - 50) @(negedge clk_i);
        holds_asked++;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lookup_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("frequency_to_flash_slot_address verification clean");
    end else begin
      $display("frequency_to_flash_slot_address verification failed");
    end
    $finish;
  end

endmodule
